### sv/sfla_pkg.sv
`timescale 1ns / 1ps

package sfla_pkg;

    // Arena geometry
    localparam int ARENA_WORDS    = 4096;
    localparam int WORD_AW        = $clog2(ARENA_WORDS);
    localparam int NUM_CLASSES    = 32;
    localparam int CLASS_W        = $clog2(NUM_CLASSES);
    localparam int CLASS_STEP     = 8;
    localparam int LINK_W         = WORD_AW + 1;
    localparam int MEM_DW         = 16;
    localparam int MIN_CHUNK      = 32;
    localparam int CHUNK_OVERHEAD = 16;
    localparam logic [15:0] ARENA_BYTES_RST = 16'd32768;

    // Commands
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_REINIT = 2'd2;

    // Result codes
    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_NOSPACE = 2'd1;
    localparam logic [1:0] RES_BAD     = 2'd2;

    // Sequencer steps
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] ST_IDLE   = 5'd0;
    localparam logic [STEP_W-1:0] ST_DECODE = 5'd1;
    localparam logic [STEP_W-1:0] ST_REINIT = 5'd2;
    localparam logic [STEP_W-1:0] ST_A0     = 5'd3;
    localparam logic [STEP_W-1:0] ST_A1     = 5'd4;
    localparam logic [STEP_W-1:0] ST_A2     = 5'd5;
    localparam logic [STEP_W-1:0] ST_A3     = 5'd6;
    localparam logic [STEP_W-1:0] ST_A4     = 5'd7;
    localparam logic [STEP_W-1:0] ST_A5     = 5'd8;
    localparam logic [STEP_W-1:0] ST_A6     = 5'd9;
    localparam logic [STEP_W-1:0] ST_F0     = 5'd10;
    localparam logic [STEP_W-1:0] ST_F1     = 5'd11;
    localparam logic [STEP_W-1:0] ST_F2     = 5'd12;
    localparam logic [STEP_W-1:0] ST_F3     = 5'd13;
    localparam logic [STEP_W-1:0] ST_F4     = 5'd14;
    localparam logic [STEP_W-1:0] ST_F5     = 5'd15;
    localparam logic [STEP_W-1:0] ST_F6     = 5'd16;
    localparam logic [STEP_W-1:0] ST_U1     = 5'd17;
    localparam logic [STEP_W-1:0] ST_U2     = 5'd18;
    localparam logic [STEP_W-1:0] ST_U3     = 5'd19;
    localparam logic [STEP_W-1:0] ST_U4     = 5'd20;
    localparam logic [STEP_W-1:0] ST_PH     = 5'd21;
    localparam logic [STEP_W-1:0] ST_P1     = 5'd22;
    localparam logic [STEP_W-1:0] ST_P2     = 5'd23;
    localparam logic [STEP_W-1:0] ST_P3     = 5'd24;
    localparam logic [STEP_W-1:0] ST_P4     = 5'd25;
    localparam logic [STEP_W-1:0] ST_P5     = 5'd26;
    localparam logic [STEP_W-1:0] ST_DONE   = 5'd27;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] req_bytes;
        logic [14:0] item_offset;
    } t_cmd_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] granted_offset;
        logic [15:0] granted_bytes;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              accept;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       fail;
        logic       take;
    } t_dp_stat;

    // Size class of a free chunk (round down)
    function automatic logic [CLASS_W-1:0] class_down(input logic [15:0] s);
        logic [12:0] q;
        q = 13'((s - 16'(MIN_CHUNK)) / 16'(CLASS_STEP));
        if (s < 16'(MIN_CHUNK)) return '0;
        if (q >= 13'(NUM_CLASSES - 1)) return CLASS_W'(NUM_CLASSES - 1);
        return q[CLASS_W-1:0];
    endfunction

    // Size class of a request (round up)
    function automatic logic [CLASS_W-1:0] class_up(input logic [16:0] n);
        logic [13:0] q;
        q = 14'((n - 17'(MIN_CHUNK) + 17'(CLASS_STEP - 1)) / 17'(CLASS_STEP));
        if (n <= 17'(MIN_CHUNK)) return '0;
        if (q > 14'(NUM_CLASSES - 1)) return CLASS_W'(NUM_CLASSES - 1);
        return q[CLASS_W-1:0];
    endfunction

endpackage

### sv/sfla_ctrl.sv
`timescale 1ns / 1ps

module sfla_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output logic              o_done,
    input  sfla_pkg::t_dp_stat i_stat,
    output sfla_pkg::t_dp_cmd  o_cmd
);
    import sfla_pkg::*;

    logic [STEP_W-1:0] r_state, n_state;
    logic [STEP_W-1:0] r_uret, n_uret;
    logic [STEP_W-1:0] r_pret, n_pret;
    logic              r_boot;
    logic              accept;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign o_done = (r_state == ST_DONE) && !r_boot;
    assign o_cmd  = '{step: r_state, accept: accept};

    // Next step
    always_comb begin
        n_state = r_state;
        n_uret  = r_uret;
        n_pret  = r_pret;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_DECODE;
            ST_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_ALLOC:  n_state = ST_A0;
                    CMD_FREE:   n_state = ST_F0;
                    CMD_REINIT: n_state = ST_REINIT;
                    default:    n_state = ST_DONE;
                endcase
            end
            ST_REINIT: begin
                n_pret  = ST_DONE;
                n_state = ST_PH;
            end
            ST_A0: n_state = i_stat.fail ? ST_DONE : ST_A1;
            ST_A1: n_state = ST_A2;
            ST_A2: begin
                if (i_stat.fail) begin
                    n_state = ST_DONE;
                end else begin
                    n_uret  = ST_A3;
                    n_state = ST_U1;
                end
            end
            ST_A3: begin
                if (i_stat.take) begin
                    n_pret  = ST_A4;
                    n_state = ST_PH;
                end else begin
                    n_state = ST_A4;
                end
            end
            ST_A4: n_state = ST_A5;
            ST_A5: n_state = ST_A6;
            ST_A6: n_state = ST_DONE;
            ST_F0: n_state = i_stat.fail ? ST_DONE : ST_F1;
            ST_F1: n_state = i_stat.fail ? ST_DONE : ST_F2;
            ST_F2: begin
                priority if (i_stat.fail) n_state = ST_DONE;
                else if (i_stat.take)    n_state = ST_F3;
                else                     n_state = ST_F4;
            end
            ST_F3: begin
                if (i_stat.take) begin
                    n_uret  = ST_F4;
                    n_state = ST_U1;
                end else begin
                    n_state = ST_F4;
                end
            end
            ST_F4: n_state = i_stat.take ? ST_F5 : ST_F6;
            ST_F5: begin
                if (i_stat.take) begin
                    n_uret  = ST_F6;
                    n_state = ST_U1;
                end else begin
                    n_state = ST_F6;
                end
            end
            ST_F6: begin
                n_pret  = ST_DONE;
                n_state = ST_PH;
            end
            ST_U1: n_state = ST_U2;
            ST_U2: n_state = ST_U3;
            ST_U3: n_state = ST_U4;
            ST_U4: n_state = r_uret;
            ST_PH: n_state = ST_P1;
            ST_P1: n_state = ST_P2;
            ST_P2: n_state = ST_P3;
            ST_P3: n_state = ST_P4;
            ST_P4: n_state = ST_P5;
            ST_P5: n_state = r_pret;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State registers; reset runs a reinitialize with no result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_REINIT;
            r_uret  <= ST_DONE;
            r_pret  <= ST_DONE;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_uret  <= n_uret;
            r_pret  <= n_pret;
            if (r_state == ST_DONE) r_boot <= 1'b0;
        end
    end

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_DECODE))
        else $error("accepted transaction did not enter decode");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> (r_state == ST_IDLE))
        else $error("done step not followed by idle");

    a_unlink_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_U1) |->
            (r_uret == ST_A3 || r_uret == ST_F4 || r_uret == ST_F6))
        else $error("unlink has no valid return step");

    a_unlink_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_U4) |=> (r_state == $past(r_uret)))
        else $error("unlink did not return to caller");

endmodule

### sv/sfla_dp.sv
`timescale 1ns / 1ps

module sfla_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfla_pkg::t_dp_cmd  i_cmd,
    input  sfla_pkg::t_cmd_in  i_req,
    input  logic [15:0]        i_arena_bytes,
    output sfla_pkg::t_dp_stat o_stat,
    output sfla_pkg::t_result  o_result
);
    import sfla_pkg::*;

    // Arena words and list heads
    logic [MEM_DW-1:0] mem [ARENA_WORDS];
    logic [LINK_W-1:0] heads [NUM_CLASSES];
    logic [MEM_DW-1:0] r_mdata;
    logic [LINK_W-1:0] r_hdata;
    logic [NUM_CLASSES-1:0] r_nonempty;

    // Transaction registers
    logic [1:0]         r_cmd;
    logic [15:0]        r_item;
    logic [14:0]        r_off;
    logic [15:0]        r_live;
    logic [16:0]        r_need;
    logic [WORD_AW-1:0] r_s, r_us, r_ps;
    logic [15:0]        r_size, r_usz, r_psz, r_tag;
    logic [LINK_W-1:0]  r_prev, r_next, r_h;
    logic [1:0]         r_status;
    logic [14:0]        r_goff;
    logic [15:0]        r_gbytes;

    // Port controls
    logic [WORD_AW-1:0] rd_addr, wr_addr;
    logic               wr_en;
    logic [MEM_DW-1:0]  wr_data;
    logic [CLASS_W-1:0] hd_raddr, hd_waddr;
    logic               hd_we;
    logic [LINK_W-1:0]  hd_wdata;

    // Helpers
    logic [16:0]        need_c;
    logic [CLASS_W-1:0] cu, found;
    logic               any_fit;
    logic [NUM_CLASSES-1:0] fit_mask;
    logic [WORD_AW-1:0] s_f0;
    logic               f0_bad;
    logic [15:0]        tsize;
    logic [16:0]        chunk_end;
    logic [15:0]        left;
    logic [15:0]        bclamp;
    logic [CLASS_W-1:0] cd_u, cd_p;
    logic [LINK_W-1:0]  ps_link;

    assign need_c    = ((17'(r_item) + 17'd7) & ~17'd7) + 17'(CHUNK_OVERHEAD);
    assign cu        = class_up(need_c);
    assign s_f0      = r_off[14:3] - WORD_AW'(1);
    assign f0_bad    = (r_off[2:0] != 3'b000) || (r_off < 15'd8)
                       || ({1'b0, s_f0, 3'b000} >= r_live);
    assign tsize     = {r_mdata[15:3], 3'b000};
    assign chunk_end = {2'b00, r_s, 3'b000} + {1'b0, r_size};
    assign left      = r_size - r_need[15:0];
    assign cd_u      = class_down(r_usz);
    assign cd_p      = class_down(r_psz);
    assign ps_link   = {1'b0, r_ps} + LINK_W'(1);

    // Lowest nonempty class at or above the request class
    always_comb begin
        fit_mask = r_nonempty & ~((NUM_CLASSES'(1) << cu) - NUM_CLASSES'(1));
        any_fit  = |fit_mask;
        found    = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (fit_mask[i]) found = CLASS_W'(i);
        end
    end

    // Arena size applied on reinitialize
    always_comb begin
        bclamp = {i_arena_bytes[15:3], 3'b000};
        if (bclamp < 16'(MIN_CHUNK)) bclamp = 16'(MIN_CHUNK);
        else if (bclamp > 16'(ARENA_WORDS * 8)) bclamp = 16'(ARENA_WORDS * 8);
    end

    // Per-step memory access and status
    always_comb begin
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        hd_raddr = '0;
        hd_we    = 1'b0;
        hd_waddr = '0;
        hd_wdata = '0;
        o_stat   = '{cmd: r_cmd, fail: 1'b0, take: 1'b0};
        unique case (i_cmd.step)
            ST_A0: begin
                hd_raddr    = found;
                o_stat.fail = (r_item < 16'd9) || !any_fit;
            end
            ST_A1: rd_addr = WORD_AW'(r_hdata - LINK_W'(1));
            ST_A2: o_stat.fail = ({1'b0, tsize} < r_need);
            ST_A3: o_stat.take = (left >= 16'(MIN_CHUNK));
            ST_A4: begin
                wr_en   = 1'b1;
                wr_addr = r_s;
                wr_data = r_size | 16'd1;
            end
            ST_A5: begin
                wr_en   = 1'b1;
                wr_addr = r_s + r_size[WORD_AW+2:3] - WORD_AW'(1);
                wr_data = r_size | 16'd1;
            end
            ST_A6: begin
                wr_en   = 1'b1;
                wr_addr = r_s + WORD_AW'(1);
                wr_data = r_item;
            end
            ST_F0: begin
                rd_addr     = s_f0;
                o_stat.fail = f0_bad;
            end
            ST_F1: begin
                rd_addr     = r_s + tsize[WORD_AW+2:3] - WORD_AW'(1);
                o_stat.fail = !r_mdata[0] || (tsize < 16'(MIN_CHUNK))
                              || (({2'b00, r_s, 3'b000} + {1'b0, tsize})
                                  > {1'b0, r_live});
            end
            ST_F2: begin
                rd_addr     = r_s - WORD_AW'(1);
                o_stat.fail = (r_mdata != r_tag);
                o_stat.take = (r_s != '0);
            end
            ST_F3: o_stat.take = !r_mdata[0] && (tsize >= 16'(MIN_CHUNK))
                                 && (tsize <= {1'b0, r_s, 3'b000});
            ST_F4: begin
                rd_addr     = chunk_end[WORD_AW+2:3];
                o_stat.take = (chunk_end < {1'b0, r_live});
            end
            ST_F5: o_stat.take = !r_mdata[0] && (tsize >= 16'(MIN_CHUNK))
                                 && ((chunk_end + {1'b0, tsize}) <= {1'b0, r_live});
            ST_U1: rd_addr = r_us + WORD_AW'(1);
            ST_U2: rd_addr = r_us + WORD_AW'(2);
            ST_U3: begin
                if (r_prev != '0) begin
                    wr_en   = 1'b1;
                    wr_addr = r_prev[WORD_AW-1:0] + WORD_AW'(1);
                    wr_data = MEM_DW'(r_mdata[LINK_W-1:0]);
                end else begin
                    hd_we    = 1'b1;
                    hd_waddr = cd_u;
                    hd_wdata = r_mdata[LINK_W-1:0];
                end
            end
            ST_U4: begin
                wr_en   = (r_next != '0);
                wr_addr = r_next[WORD_AW-1:0];
                wr_data = MEM_DW'(r_prev);
            end
            ST_PH: hd_raddr = cd_p;
            ST_P1: begin
                wr_en   = 1'b1;
                wr_addr = r_ps;
                wr_data = r_psz;
            end
            ST_P2: begin
                wr_en   = 1'b1;
                wr_addr = r_ps + r_psz[WORD_AW+2:3] - WORD_AW'(1);
                wr_data = r_psz;
            end
            ST_P3: begin
                wr_en   = 1'b1;
                wr_addr = r_ps + WORD_AW'(1);
                wr_data = '0;
            end
            ST_P4: begin
                wr_en   = 1'b1;
                wr_addr = r_ps + WORD_AW'(2);
                wr_data = MEM_DW'(r_h);
            end
            ST_P5: begin
                wr_en    = (r_h != '0);
                wr_addr  = r_h[WORD_AW-1:0];
                wr_data  = MEM_DW'(ps_link);
                hd_we    = 1'b1;
                hd_waddr = cd_p;
                hd_wdata = ps_link;
            end
            default: ;
        endcase
    end

    // Arena memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_mdata <= mem[rd_addr];
    end

    // Head memory, registered read
    always_ff @(posedge i_clk) begin
        if (hd_we) heads[hd_waddr] <= hd_wdata;
        r_hdata <= heads[hd_raddr];
    end

    // Nonempty bits stand in for cleared heads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
        end else if (i_cmd.step == ST_REINIT) begin
            r_nonempty <= '0;
        end else if (hd_we) begin
            r_nonempty[hd_waddr] <= (hd_wdata != '0);
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd    <= i_req.command;
            r_item   <= i_req.req_bytes;
            r_off    <= i_req.item_offset;
            r_status <= RES_OK;
            r_goff   <= '0;
            r_gbytes <= '0;
        end
        unique case (i_cmd.step)
            ST_DECODE: begin
                if (r_cmd != CMD_ALLOC && r_cmd != CMD_FREE && r_cmd != CMD_REINIT) begin
                    r_status <= RES_BAD;
                end
            end
            ST_REINIT: begin
                r_live <= bclamp;
                r_ps   <= '0;
                r_psz  <= bclamp;
            end
            ST_A0: begin
                r_need <= need_c;
                if (r_item < 16'd9) r_status <= RES_BAD;
                else if (!any_fit)  r_status <= RES_NOSPACE;
            end
            ST_A1: r_s <= WORD_AW'(r_hdata - LINK_W'(1));
            ST_A2: begin
                if ({1'b0, tsize} < r_need) r_status <= RES_NOSPACE;
                r_size <= tsize;
                r_us   <= r_s;
                r_usz  <= tsize;
            end
            ST_A3: begin
                if (left >= 16'(MIN_CHUNK)) begin
                    r_ps   <= r_s + r_need[WORD_AW+2:3];
                    r_psz  <= left;
                    r_size <= r_need[15:0];
                end
            end
            ST_A6: begin
                r_goff   <= {r_s, 3'b000} + 15'd8;
                r_gbytes <= r_size;
            end
            ST_F0: begin
                r_s <= s_f0;
                if (f0_bad) r_status <= RES_BAD;
            end
            ST_F1: begin
                r_tag  <= r_mdata;
                r_size <= tsize;
                if (o_stat.fail) r_status <= RES_BAD;
            end
            ST_F2: if (o_stat.fail) r_status <= RES_BAD;
            ST_F3: begin
                if (o_stat.take) begin
                    r_us   <= r_s - tsize[WORD_AW+2:3];
                    r_s    <= r_s - tsize[WORD_AW+2:3];
                    r_usz  <= tsize;
                    r_size <= r_size + tsize;
                end
            end
            ST_F5: begin
                if (o_stat.take) begin
                    r_us   <= chunk_end[WORD_AW+2:3];
                    r_usz  <= tsize;
                    r_size <= r_size + tsize;
                end
            end
            ST_F6: begin
                r_ps  <= r_s;
                r_psz <= r_size;
            end
            ST_U2: r_prev <= r_mdata[LINK_W-1:0];
            ST_U3: r_next <= r_mdata[LINK_W-1:0];
            ST_P1: r_h <= r_nonempty[cd_p] ? r_hdata : '0;
            default: ;
        endcase
    end

    assign o_result = '{status: r_status, granted_offset: r_goff, granted_bytes: r_gbytes};

endmodule

### sv/segregated_free_list_allocator.sv
`timescale 1ns / 1ps

// Heap allocator over a 4096-word arena with per-class free lists and
// boundary-tag coalescing. Raise start with a command while busy is low; the
// block answers each transaction with exactly one result on o_result, marked
// by o_done for a single cycle, and the receiver cannot stall it. One
// transaction occupies the block from accept to result: an allocate takes
// longer when a leftover chunk is split off, a deallocate takes longer the
// more neighbors are merged, and unknown, bad or unfittable requests end
// early. The block then returns to idle before the next accept. Transaction
// length is set by the arena memory's registered read and single write per
// cycle: every tag read, link update and tag write is its own step, issued
// one after another by the sequencer. After reset the block builds the
// initial free chunk with busy high; arena_bytes is taken up only on a
// reinitialize.
module segregated_free_list_allocator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sfla_pkg::t_cmd_in i_cmd,
    output logic              o_done,
    output sfla_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import sfla_pkg::*;

    logic [15:0] r_arena_bytes;
    t_dp_cmd     dp_cmd;
    t_dp_stat    dp_stat;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_arena_bytes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_bytes <= ARENA_BYTES_RST;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_arena_bytes <= pwdata[15:0];
        end
    end

    // Sequencer
    sfla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Arena, heads and working registers
    sfla_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_req         (i_cmd),
        .i_arena_bytes (r_arena_bytes),
        .o_stat        (dp_stat),
        .o_result      (o_result)
    );

endmodule
